// File: hdl/ptr_pkg.sv
// shared types, constants and helpers for the prescaled timer
package ptr_pkg;

	localparam logic [15:0] BASE_ADDRESS = 16'd65284;
	localparam int TICK_BITS = 8;
	localparam logic [7:0] TICK_MASK = 8'((1 << TICK_BITS) - 1);

	localparam int IN_DATA_W = 32;
	localparam int IN_USER_W = 2;
	localparam int OUT_DATA_W = 16;

	// wide enough for prescaler plus one tick
	localparam int PRE_W = 11;

	typedef enum logic [1:0] {
		OP_TICK  = 2'd0,
		OP_READ  = 2'd1,
		OP_WRITE = 2'd2,
		OP_NONE  = 2'd3
	} opcode_t;

	typedef enum logic [1:0] {
		STAT_OK       = 2'd0,
		STAT_BAD_ADDR = 2'd1,
		STAT_BAD_CTRL = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		REG_DIV  = 2'd0,
		REG_CNT  = 2'd1,
		REG_MOD  = 2'd2,
		REG_CTRL = 2'd3
	} reg_sel_t;

	localparam logic [7:0] CTRL_MAX = 8'd7;
	localparam int CTRL_EN_BIT = 2;

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_STEP
	} state_t;

	typedef struct packed {
		logic load_in;
		logic exec;
		logic step;
		logic finish;
	} cmd_t;

	typedef struct packed {
		logic step_needed;
		logic out_free;
	} stat_t;

	function automatic logic [PRE_W-1:0] period_of(input logic [1:0] sel);
		logic [PRE_W-1:0] p;
		case (sel)
			2'd0: p = PRE_W'(1024);
			2'd1: p = PRE_W'(16);
			2'd2: p = PRE_W'(64);
			2'd3: p = PRE_W'(256);
			default: p = PRE_W'(1024);
		endcase
		return p;
	endfunction

endpackage

// File: hdl/ptr_ctrl.sv
// sequencer: accept, execute, step the counter, hand off the result
module ptr_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_tvalid,
	output logic          s_tready,
	input  ptr_pkg::stat_t stat,
	output ptr_pkg::cmd_t  cmd
);
	import ptr_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (s_tvalid) state_d = S_EXEC;
			end
			S_EXEC: begin
				state_d = S_STEP;
			end
			S_STEP: begin
				if (!stat.step_needed && stat.out_free) state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_comb begin
		s_tready = 1'b0;
		cmd = '0;
		case (state_q)
			S_IDLE: begin
				s_tready = 1'b1;
				cmd.load_in = s_tvalid;
			end
			S_EXEC: begin
				cmd.exec = 1'b1;
			end
			S_STEP: begin
				cmd.step = stat.step_needed;
				cmd.finish = !stat.step_needed && stat.out_free;
			end
			default: begin
				s_tready = 1'b0;
			end
		endcase
	end

	// one command at a time
	a_cmd_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.load_in, cmd.exec, cmd.step, cmd.finish}))
		else $error("more than one command issued");
	a_exec_after_load: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_in |=> cmd.exec)
		else $error("execute did not follow a load");
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.exec || cmd.step) |-> !s_tready)
		else $error("input ready while busy");

endmodule

// File: hdl/ptr_dp.sv
// timer registers, prescalers, register file access and result register
module ptr_dp (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic [ptr_pkg::IN_DATA_W-1:0]    s_tdata,
	input  logic [ptr_pkg::IN_USER_W-1:0]    s_tuser,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [ptr_pkg::OUT_DATA_W-1:0]   m_tdata,
	input  ptr_pkg::cmd_t                    cmd,
	output ptr_pkg::stat_t                   stat
);
	import ptr_pkg::*;

	// captured beat
	opcode_t     opc_q;
	logic [7:0]  ticks_q;
	logic [15:0] addr_q;
	logic [7:0]  wdata_q;

	// timer state
	logic [7:0]       div_q;
	logic [7:0]       div_pre_q;
	logic [7:0]       cnt_q;
	logic [7:0]       mod_q;
	logic [7:0]       ctrl_q;
	logic [9:0]       cnt_pre_q;

	// working values for one beat
	logic [PRE_W-1:0] acc_q;
	logic             run_q;
	logic             irq_q;
	logic [7:0]       rv_q;
	status_t          status_q;

	// result register
	logic             out_valid_q;
	logic [7:0]       out_rv_q;
	logic             out_irq_q;
	status_t          out_status_q;

	logic [PRE_W-1:0] period;
	logic [16:0]      off_full;
	logic             in_range;
	reg_sel_t         sel;
	logic [8:0]       div_sum;
	logic [7:0]       cnt_inc;

	assign period   = period_of(ctrl_q[1:0]);
	assign off_full = {1'b0, addr_q} - {1'b0, BASE_ADDRESS};
	assign in_range = !off_full[16] && (off_full[15:2] == 14'd0);
	assign sel      = reg_sel_t'(off_full[1:0]);
	assign div_sum  = {1'b0, div_pre_q} + {1'b0, ticks_q};
	assign cnt_inc  = cnt_q + 8'd1;

	assign stat.step_needed = run_q && (acc_q >= period);
	assign stat.out_free    = !out_valid_q || m_tready;

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			opc_q   <= opcode_t'(s_tuser[1:0]);
			ticks_q <= s_tdata[7:0] & TICK_MASK;
			addr_q  <= s_tdata[23:8];
			wdata_q <= s_tdata[31:24];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_q     <= '0;
			div_pre_q <= '0;
			cnt_q     <= '0;
			mod_q     <= '0;
			ctrl_q    <= '0;
			cnt_pre_q <= '0;
			acc_q     <= '0;
			run_q     <= 1'b0;
			irq_q     <= 1'b0;
			rv_q      <= '0;
			status_q  <= STAT_OK;
		end else if (cmd.exec) begin
			irq_q    <= 1'b0;
			rv_q     <= '0;
			status_q <= STAT_OK;
			run_q    <= 1'b0;
			case (opc_q)
				OP_TICK: begin
					div_pre_q <= div_sum[7:0];
					if (div_sum[8]) div_q <= div_q + 8'd1;
					if (ctrl_q[CTRL_EN_BIT]) begin
						run_q <= 1'b1;
						acc_q <= {1'b0, cnt_pre_q} + {3'b000, ticks_q};
					end
				end
				OP_READ: begin
					if (!in_range) begin
						status_q <= STAT_BAD_ADDR;
					end else begin
						case (sel)
							REG_DIV:  rv_q <= div_q;
							REG_CNT:  rv_q <= cnt_q;
							REG_MOD:  rv_q <= mod_q;
							REG_CTRL: rv_q <= ctrl_q;
							default:  rv_q <= '0;
						endcase
					end
				end
				OP_WRITE: begin
					if (!in_range) begin
						status_q <= STAT_BAD_ADDR;
					end else begin
						case (sel)
							REG_DIV: begin
								div_q     <= '0;
								div_pre_q <= '0;
								cnt_pre_q <= '0;
							end
							REG_CNT:  cnt_q <= wdata_q;
							REG_MOD:  mod_q <= wdata_q;
							REG_CTRL: begin
								ctrl_q    <= wdata_q;
								cnt_pre_q <= '0;
								if (wdata_q > CTRL_MAX) status_q <= STAT_BAD_CTRL;
							end
							default: begin
								cnt_q <= cnt_q;
							end
						endcase
					end
				end
				default: begin
					run_q <= 1'b0;
				end
			endcase
		end else if (cmd.step) begin
			// one period per cycle, reload on wrap
			acc_q <= acc_q - period;
			if (cnt_inc == 8'd0) begin
				cnt_q <= mod_q;
				irq_q <= 1'b1;
			end else begin
				cnt_q <= cnt_inc;
			end
		end else if (cmd.finish) begin
			if (run_q) cnt_pre_q <= acc_q[9:0];
			run_q <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.finish) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			out_rv_q     <= rv_q;
			out_irq_q    <= irq_q;
			out_status_q <= status_q;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {5'd0, out_status_q, out_irq_q, out_rv_q};

	a_pre_below_period: assert property (@(posedge clk) disable iff (!arst_n)
		{1'b0, cnt_pre_q} < period)
		else $error("counter prescaler reached its period");
	a_step_shrinks: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.step |=> acc_q < $past(acc_q))
		else $error("prescaler accumulator did not shrink on a step");
	a_irq_only_tick: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.finish && opc_q != OP_TICK) |-> !irq_q)
		else $error("interrupt raised outside a tick");
	a_finish_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |=> m_tvalid)
		else $error("result not presented after finish");

endmodule

// File: hdl/prescaled_timer_with_reload.sv
// prescaled timer with reload: top level joining sequencer and datapath
// one beat at a time: it is loaded, executed, stepped n times (n = counter steps, 0..16)
// and handed off when the output is free; the counter steps one period per cycle
// a waiting result sits in an output register while the next beat is taken
// reset (arst_n low, asynchronous): all timer registers and prescalers clear to zero
module prescaled_timer_with_reload (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	// tick_count[7:0], bus_address[23:8], write_value[31:24]
	input  logic [ptr_pkg::IN_DATA_W-1:0]  s_tdata,
	// opcode[1:0]
	input  logic [ptr_pkg::IN_USER_W-1:0]  s_tuser,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// read_value[7:0], irq_request[8], status[10:9], zero[15:11]
	output logic [ptr_pkg::OUT_DATA_W-1:0] m_tdata
);
	import ptr_pkg::*;

	cmd_t  cmd;
	stat_t stat;

	ptr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	ptr_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cmd      (cmd),
		.stat     (stat)
	);

endmodule

// File: sim/prescaled_timer_with_reload_tb.sv
// self-checking testbench for the prescaled timer with reload: directed table, then random bus traffic
`timescale 1ns / 1ps

module prescaled_timer_with_reload_tb;
	import ptr_pkg::*;

	localparam int RANDOM_ITEMS = 650;
	localparam int STALL_PCT = 36;
	localparam int DRAIN_CYCLES = 40;
	localparam int HANG_LIMIT = 4000;

	typedef struct packed {
		opcode_t     op;
		logic [7:0]  ticks;
		logic [15:0] addr;
		logic [7:0]  wval;
	} bus_op_t;

	typedef struct packed {
		logic [7:0] read_value;
		logic       irq;
		status_t    status;
	} timer_reply_t;

	typedef struct packed {
		bus_op_t      cmd;
		logic         typed;
		timer_reply_t want;
	} dir_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [IN_DATA_W-1:0] s_tdata = '0;
	logic [IN_USER_W-1:0] s_tuser = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;

	// shadow of the timer registers
	logic [7:0] div_reg, div_pre, cnt_reg, mod_reg, ctrl_reg;
	logic [9:0] cnt_pre;

	timer_reply_t pending_replies[$];
	dir_row_t directed_rows[$];
	int mismatches = 0;
	int quiet_cycles = 0;
	bit steady_run = 1'b0;

	prescaled_timer_with_reload DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic timer_reply_t advance_timer(input bus_op_t c);
		timer_reply_t r;
		int clocks;
		int acc;
		int period;
		int off;
		r.read_value = '0;
		r.irq = 1'b0;
		r.status = STAT_OK;
		case (c.op)
			OP_TICK: begin
				clocks = int'(c.ticks & TICK_MASK);
				acc = int'(div_pre) + clocks;
				if (acc >= 256) begin
					acc -= 256;
					div_reg = div_reg + 8'd1;
				end
				div_pre = 8'(acc);
				if (ctrl_reg[CTRL_EN_BIT]) begin
					case (ctrl_reg[1:0])
						2'd0: period = 1024;
						2'd1: period = 16;
						2'd2: period = 64;
						default: period = 256;
					endcase
					acc = int'(cnt_pre) + clocks;
					while (acc >= period) begin
						acc -= period;
						cnt_reg = cnt_reg + 8'd1;
						// wrap reloads from modulo
						if (cnt_reg == 8'd0) begin
							cnt_reg = mod_reg;
							r.irq = 1'b1;
						end
					end
					cnt_pre = 10'(acc);
				end
			end
			OP_READ, OP_WRITE: begin
				off = int'(c.addr) - int'(BASE_ADDRESS);
				if (off < 0 || off > 3) begin
					r.status = STAT_BAD_ADDR;
				end else if (c.op == OP_READ) begin
					case (reg_sel_t'(2'(off)))
						REG_DIV: r.read_value = div_reg;
						REG_CNT: r.read_value = cnt_reg;
						REG_MOD: r.read_value = mod_reg;
						default: r.read_value = ctrl_reg;
					endcase
				end else begin
					case (reg_sel_t'(2'(off)))
						REG_DIV: begin
							div_reg = '0;
							div_pre = '0;
							cnt_pre = '0;
						end
						REG_CNT: cnt_reg = c.wval;
						REG_MOD: mod_reg = c.wval;
						default: begin
							ctrl_reg = c.wval;
							cnt_pre = '0;
							if (c.wval > CTRL_MAX)
								r.status = STAT_BAD_CTRL;
						end
					endcase
				end
			end
			default: ;
		endcase
		return r;
	endfunction

	function automatic logic [15:0] pick_address();
		int r;
		r = $urandom_range(0, 99);
		if (r < 88)
			return BASE_ADDRESS + 16'($urandom_range(0, 3));
		else if (r < 92)
			return BASE_ADDRESS - 16'd1;
		else if (r < 96)
			return BASE_ADDRESS + 16'd4;
		return 16'($urandom_range(0, 65535));
	endfunction

	function automatic bus_op_t draw_bus_op();
		bus_op_t c;
		int r;
		c.op = OP_TICK;
		c.ticks = 8'($urandom_range(0, 255));
		c.addr = 16'($urandom_range(0, 65535));
		c.wval = 8'($urandom_range(0, 255));
		r = $urandom_range(0, 99);
		if (r < 45) begin
			c.op = OP_TICK;
		end else if (r < 65) begin
			c.op = OP_READ;
			c.addr = pick_address();
		end else if (r < 92) begin
			c.op = OP_WRITE;
			r = $urandom_range(0, 99);
			if (r < 10) begin
				c.addr = BASE_ADDRESS + 16'(REG_DIV);
			end else if (r < 40) begin
				c.addr = BASE_ADDRESS + 16'(REG_CNT);
				// park the counter near the top so wraps come often
				if ($urandom_range(0, 99) < 70)
					c.wval = 8'($urandom_range(8'hF0, 8'hFF));
			end else if (r < 65) begin
				c.addr = BASE_ADDRESS + 16'(REG_MOD);
			end else if (r < 95) begin
				c.addr = BASE_ADDRESS + 16'(REG_CTRL);
				r = $urandom_range(0, 99);
				if (r < 80)
					c.wval = 8'(4 + $urandom_range(0, 3));
				else if (r < 90)
					c.wval = 8'($urandom_range(0, 3));
			end else begin
				c.addr = pick_address();
			end
		end else if (r < 96) begin
			c.op = OP_NONE;
		end else begin
			c.op = ($urandom_range(0, 1) != 0) ? OP_READ : OP_WRITE;
		end
		return c;
	endfunction

	task automatic add_row(input opcode_t op, input logic [7:0] ticks, input logic [15:0] addr,
			input logic [7:0] wval, input logic typed, input logic [7:0] rv, input status_t st);
		dir_row_t row;
		row.cmd.op = op;
		row.cmd.ticks = ticks;
		row.cmd.addr = addr;
		row.cmd.wval = wval;
		row.typed = typed;
		row.want.read_value = rv;
		row.want.irq = 1'b0;
		row.want.status = st;
		directed_rows.push_back(row);
	endtask

	task automatic send_beat(input bus_op_t c, input logic typed, input timer_reply_t want);
		timer_reply_t got;
		while (!steady_run && $urandom_range(0, 99) < STALL_PCT) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {c.wval, c.addr, c.ticks};
		s_tuser <= c.op;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		got = advance_timer(c);
		pending_replies.push_back(typed ? want : got);
	endtask

	// result side: check each beat and stall at random
	always @(posedge clk) begin
		timer_reply_t exp_reply;
		if (m_tvalid && m_tready) begin
			if (pending_replies.size() == 0) begin
				$error("result beat with no expectation pending: tdata %h", m_tdata);
				mismatches++;
			end else begin
				exp_reply = pending_replies.pop_front();
				if (m_tdata[7:0] !== exp_reply.read_value) begin
					$error("read_value: expected %h, got %h", exp_reply.read_value, m_tdata[7:0]);
					mismatches++;
				end
				if (m_tdata[8] !== exp_reply.irq) begin
					$error("irq_request: expected %b, got %b", exp_reply.irq, m_tdata[8]);
					mismatches++;
				end
				if (m_tdata[10:9] !== exp_reply.status) begin
					$error("status: expected %0d, got %0d", exp_reply.status, m_tdata[10:9]);
					mismatches++;
				end
			end
		end
		m_tready <= steady_run || ($urandom_range(0, 99) >= STALL_PCT);
	end

	// hang detection: too long without any beat on either side
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= HANG_LIMIT) begin
				$display("*** FAILED ***");
				$finish;
			end
		end
	end

	initial begin
		dir_row_t row;
		bus_op_t c;
		timer_reply_t none;
		none = '0;
		div_reg = '0;
		div_pre = '0;
		cnt_reg = '0;
		mod_reg = '0;
		ctrl_reg = '0;
		cnt_pre = '0;

		// registers read zero after reset
		add_row(OP_READ, 8'h00, BASE_ADDRESS + 16'(REG_DIV), 8'h00, 1'b1, 8'h00, STAT_OK);
		add_row(OP_READ, 8'h00, BASE_ADDRESS + 16'(REG_CNT), 8'h00, 1'b1, 8'h00, STAT_OK);
		add_row(OP_READ, 8'h00, BASE_ADDRESS + 16'(REG_MOD), 8'h00, 1'b1, 8'h00, STAT_OK);
		add_row(OP_READ, 8'h00, BASE_ADDRESS + 16'(REG_CTRL), 8'h00, 1'b1, 8'h00, STAT_OK);
		// timer disabled: only the divider runs, and the two ticks together step it once
		add_row(OP_TICK, 8'hFF, 16'h0000, 8'h00, 1'b1, 8'h00, STAT_OK);
		add_row(OP_TICK, 8'h01, 16'hFFFF, 8'hFF, 1'b1, 8'h00, STAT_OK);
		add_row(OP_READ, 8'h00, BASE_ADDRESS + 16'(REG_DIV), 8'h00, 1'b1, 8'h01, STAT_OK);
		// addresses just outside the window and the far ends
		add_row(OP_READ, 8'h00, BASE_ADDRESS - 16'd1, 8'h00, 1'b1, 8'h00, STAT_BAD_ADDR);
		add_row(OP_WRITE, 8'h00, BASE_ADDRESS + 16'd4, 8'hFF, 1'b1, 8'h00, STAT_BAD_ADDR);
		add_row(OP_READ, 8'hFF, 16'hFFFF, 8'h00, 1'b1, 8'h00, STAT_BAD_ADDR);
		add_row(OP_WRITE, 8'h00, 16'h0000, 8'h55, 1'b1, 8'h00, STAT_BAD_ADDR);
		// counter near the top, fast period: wraps inside one tick
		add_row(OP_WRITE, 8'h00, BASE_ADDRESS + 16'(REG_MOD), 8'hFF, 1'b1, 8'h00, STAT_OK);
		add_row(OP_WRITE, 8'h00, BASE_ADDRESS + 16'(REG_CNT), 8'hFE, 1'b1, 8'h00, STAT_OK);
		add_row(OP_WRITE, 8'h00, BASE_ADDRESS + 16'(REG_CTRL), 8'h05, 1'b1, 8'h00, STAT_OK);
		add_row(OP_TICK, 8'hFF, 16'h0000, 8'h00, 1'b0, 8'h00, STAT_OK);
		add_row(OP_READ, 8'h00, BASE_ADDRESS + 16'(REG_CNT), 8'h00, 1'b0, 8'h00, STAT_OK);
		add_row(OP_TICK, 8'h00, 16'h0000, 8'h00, 1'b0, 8'h00, STAT_OK);
		add_row(OP_WRITE, 8'h00, BASE_ADDRESS + 16'(REG_CTRL), 8'h06, 1'b1, 8'h00, STAT_OK);
		add_row(OP_TICK, 8'hFF, 16'h0000, 8'h00, 1'b0, 8'h00, STAT_OK);
		// control byte above the legal range is kept but flagged
		add_row(OP_WRITE, 8'h00, BASE_ADDRESS + 16'(REG_CTRL), 8'hFF, 1'b1, 8'h00, STAT_BAD_CTRL);
		add_row(OP_READ, 8'h00, BASE_ADDRESS + 16'(REG_CTRL), 8'h00, 1'b1, 8'hFF, STAT_OK);
		add_row(OP_TICK, 8'hFF, 16'h0000, 8'h00, 1'b0, 8'h00, STAT_OK);
		// any divider write clears it
		add_row(OP_WRITE, 8'h00, BASE_ADDRESS + 16'(REG_DIV), 8'hAB, 1'b1, 8'h00, STAT_OK);
		add_row(OP_READ, 8'h00, BASE_ADDRESS + 16'(REG_DIV), 8'h00, 1'b1, 8'h00, STAT_OK);
		// unused opcode answers all zero
		add_row(OP_NONE, 8'hFF, 16'hFFFF, 8'hFF, 1'b1, 8'h00, STAT_OK);
		add_row(OP_WRITE, 8'h00, BASE_ADDRESS + 16'(REG_CTRL), 8'h00, 1'b1, 8'h00, STAT_OK);
		add_row(OP_TICK, 8'hC8, 16'h0000, 8'h00, 1'b0, 8'h00, STAT_OK);

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i]) begin
			row = directed_rows[i];
			send_beat(row.cmd, row.typed, row.want);
		end

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			// a long stretch with neither side idling
			steady_run = (n >= 250 && n < 400);
			c = draw_bus_op();
			send_beat(c, 1'b0, none);
		end
		steady_run = 1'b0;
		s_tvalid <= 1'b0;

		while (pending_replies.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
